FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, constants and helpers of the stream find and replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int DEF_MAX_PATTERN     = 16;
   localparam int DEF_MAX_REPLACEMENT = 16;
   localparam int WIN_BYTES           = 16;
   localparam int CNT_W               = 5;
   localparam int WORD_W              = 64;
   localparam int CSR_IDX_W           = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HI  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_LO  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_HI  = 3'd5;

   typedef struct packed {
      logic [WIN_BYTES-1:0][7:0] win;
      logic [CNT_W-1:0]          total;
      logic                      repl;
      logic                      last_text;
   } entry_type;

   function automatic logic [7:0] word_byte(input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] hi,
                                            input logic [3:0] idx);
      logic [WORD_W-1:0] w;
      w = idx[3] ? hi : lo;
      return w[{idx[2:0], 3'b000} +: 8];
   endfunction

endpackage

FILE: rtl/core/sfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front
// holds the pending prefix, finds the earliest consistent start per request
// ----------------------------------------------------------------------------
module sfr_front #(
   parameter int LIMP = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    text_byte,
   input  logic                          text_end,
   input  logic                          cfg_clear,
   input  logic [sfr_pkg::CNT_W-1:0]     pat_len,
   input  logic [sfr_pkg::CNT_W-1:0]     rep_len,
   input  logic [sfr_pkg::WORD_W-1:0]    pat_lo,
   input  logic [sfr_pkg::WORD_W-1:0]    pat_hi,
   output logic                          push,
   output sfr_pkg::entry_type            entry
);
   import sfr_pkg::*;

   logic [LIMP-1:0][7:0] held_ff, held_in;
   logic [CNT_W-1:0]     hc_ff, hc_in;
   logic [CNT_W-1:0]     hc, n, first;
   logic [LIMP-1:0][7:0] win, shifted;
   logic [LIMP-1:0]      ok;
   logic                 full;

   always_comb begin
      hc = (hc_ff >= pat_len) ? '0 : hc_ff;
      n  = hc + CNT_W'(1);
      for (int k = 0; k < LIMP; k++) begin
         if (CNT_W'(k) < hc) win[k] = held_ff[k];
         else if (CNT_W'(k) == hc) win[k] = text_byte;
         else win[k] = 8'd0;
      end
      for (int i = 0; i < LIMP; i++) begin
         ok[i] = 1'b1;
         for (int k = 0; k < LIMP; k++) begin
            if (i + k < LIMP) begin
               if (CNT_W'(i + k) < n && win[i+k] != word_byte(pat_lo, pat_hi, 4'(k)))
                  ok[i] = 1'b0;
            end
         end
      end
      first = n;
      for (int i = LIMP - 1; i >= 0; i--) begin
         if (ok[i] && CNT_W'(i) < n) first = CNT_W'(i);
      end
      full = (first == '0) && (n == pat_len);
      for (int k = 0; k < LIMP; k++) begin
         shifted[k] = 8'd0;
         for (int s = 0; s < LIMP; s++) begin
            if (CNT_W'(s) == first && s + k < LIMP) shifted[k] = win[s+k];
         end
      end
   end

   always_comb begin
      entry     = '0;
      for (int k = 0; k < LIMP; k++) entry.win[k] = win[k];
      entry.repl      = full;
      entry.last_text = text_end;
      if (full) entry.total = rep_len;
      else if (text_end) entry.total = n;
      else entry.total = first;
      push = accept && (entry.total != '0 || text_end);
   end

   always_comb begin
      held_in = held_ff;
      hc_in   = hc_ff;
      if (cfg_clear) begin
         hc_in = '0;
      end else if (accept) begin
         held_in = shifted;
         hc_in   = (full || text_end) ? '0 : n - first;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) hc_ff <= '0;
      else hc_ff <= hc_in;
   end

endmodule

FILE: rtl/core/sfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_queue
// two-entry queue between classifier and emitter
// ----------------------------------------------------------------------------
module sfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfr_pkg::entry_type push_data,
   input  logic               pop,
   output sfr_pkg::entry_type pop_data,
   output logic               full,
   output logic               empty
);
   import sfr_pkg::*;

   entry_type  mem [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rp_ff];

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/sfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_back
// emits the bytes of each queued entry one per cycle while rsp_tready is high
// ----------------------------------------------------------------------------
module sfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  sfr_pkg::entry_type         q_data,
   output logic                       q_pop,
   input  logic [sfr_pkg::WORD_W-1:0] rep_lo,
   input  logic [sfr_pkg::WORD_W-1:0] rep_hi,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,  // out_byte
   output logic                       rsp_tlast,  // run_last
   output logic [1:0]                 rsp_tuser   // has_byte, stream_end
);
   import sfr_pkg::*;

   entry_type        cur_ff, cur_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             last, fire, has;

   always_comb begin
      has        = cur_ff.total != '0;
      last       = !has || (j_ff == cur_ff.total - CNT_W'(1));
      fire       = busy_ff && rsp_tready;
      rsp_tvalid = busy_ff;
      rsp_tlast  = last;
      rsp_tuser  = {last && cur_ff.last_text, has};
      if (!has) rsp_tdata = 8'd0;
      else if (cur_ff.repl) rsp_tdata = word_byte(rep_lo, rep_hi, j_ff[3:0]);
      else rsp_tdata = cur_ff.win[j_ff[3:0]];
      q_pop   = (!busy_ff || (fire && last)) && !q_empty;
      cur_in  = q_pop ? q_data : cur_ff;
      busy_in = q_pop ? 1'b1 : ((fire && last) ? 1'b0 : busy_ff);
      if (q_pop) j_in = '0;
      else if (fire) j_in = j_ff + CNT_W'(1);
      else j_in = j_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      j_ff   <= j_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

endmodule

FILE: rtl/core/stream_find_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace
// streaming find and replace of a configured pattern in a byte stream
// path: an accepted request's entry is registered in the queue, then in the emitter
// throughput: one result byte per cycle while rsp_tready is high; requests
// with no result reach the emitter only when they end the text, and the
// two-entry queue absorbs short bursts
// reset: synchronous, clears held bytes, queue and emitter; pattern length 1
// ----------------------------------------------------------------------------
module stream_find_replace #(
   parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
   parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // text_byte
   input  logic                          req_tlast,  // text_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // out_byte
   output logic                          rsp_tlast,  // run_last
   output logic [1:0]                    rsp_tuser,  // has_byte, stream_end
   input  logic                          csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfr_pkg::WORD_W-1:0]    csr_wdata
);
   import sfr_pkg::*;

   localparam int LIMP = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
   localparam int LIMR = (MAX_REPLACEMENT < 16) ? MAX_REPLACEMENT : 16;

   logic [CNT_W-1:0]  plen_ff, rlen_ff, p_eff, r_eff;
   logic [WORD_W-1:0] plo_ff, phi_ff, rlo_ff, rhi_ff;
   logic              accept, push, q_full, q_empty, q_pop, cfg_clear;
   entry_type         entry, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= CNT_W'(1);
         rlen_ff <= '0;
         plo_ff  <= '0;
         phi_ff  <= '0;
         rlo_ff  <= '0;
         rhi_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAT_LEN: plen_ff <= csr_wdata[CNT_W-1:0];
            CSR_PAT_LO:  plo_ff  <= csr_wdata;
            CSR_PAT_HI:  phi_ff  <= csr_wdata;
            CSR_REP_LEN: rlen_ff <= csr_wdata[CNT_W-1:0];
            CSR_REP_LO:  rlo_ff  <= csr_wdata;
            CSR_REP_HI:  rhi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (plen_ff == '0) p_eff = CNT_W'(1);
      else if (plen_ff > CNT_W'(LIMP)) p_eff = CNT_W'(LIMP);
      else p_eff = plen_ff;
      r_eff = (rlen_ff > CNT_W'(LIMR)) ? CNT_W'(LIMR) : rlen_ff;
      cfg_clear = csr_we && (csr_index == CSR_PAT_LEN || csr_index == CSR_PAT_LO
                             || csr_index == CSR_PAT_HI);
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   sfr_front #(.LIMP(LIMP)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_tdata),
      .text_end  (req_tlast),
      .cfg_clear (cfg_clear),
      .pat_len   (p_eff),
      .rep_len   (r_eff),
      .pat_lo    (plo_ff),
      .pat_hi    (phi_ff),
      .push      (push),
      .entry     (entry)
   );

   sfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rep_lo     (rlo_ff),
      .rep_hi     (rhi_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
